>>> rtl/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
// Holds the ASCII codes, the pipeline control struct, the serialiser states
// and the digit-count helper. Depends on nothing.
package sbda_pkg;

    // ASCII codes used in the output text.
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Width of one BCD digit.
    localparam int DIGIT_BITS = 4;

    // Shift steps of double dabble carried out in one pipeline stage.
    localparam int STEPS_PER_STAGE = 4;

    // Control that travels alongside the data through the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } t_stage_ctl;

    // Output serialiser states.
    typedef enum logic [1:0] {
        SER_IDLE,
        SER_SIGN,
        SER_DIGITS
    } t_ser_state;

    // Decimal digits needed for the largest magnitude, 2^(bits-1).
    function automatic int num_digits(input int bits);
        longint unsigned v;
        int              n;
        begin
            v = 64'd1 << (bits - 1);
            n = 0;
            for (int i = 0; i < 20; i++) begin
                if (v != 0) begin
                    n = n + 1;
                    v = v / 10;
                end
            end
            return n;
        end
    endfunction

endpackage

>>> rtl/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
// Uses sbda_pkg, sbda_dabble_stage and sbda_serializer.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------
//   input   | start, busy          | i_value (VALUE_BITS, signed)
//   output  | o_strobe             | o_character (8), o_last_char
//
// A number is taken into a sign/magnitude register, then passes through
// ceil(VALUE_BITS/4) double dabble stages to the serialiser, which loads
// it into its state, digit and count registers. The serialiser then sends
// one character per cycle: digit count plus one for a negative value, at most
// six at 16 bits, and that count sets the sustained rate per number.
// Reset is synchronous and active low; it clears valid bits and the serialiser state.
// The receiver cannot stall; busy rises while the pipeline waits on the
// serialiser, and the whole pipeline holds until it can hand over.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         busy,
    output logic                         o_strobe,
    output logic [7:0]                   o_character,
    output logic                         o_last_char
);

    localparam int N_DIGITS = num_digits(VALUE_BITS);
    localparam int BCD_W    = N_DIGITS * DIGIT_BITS;
    localparam int N_STAGES = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    t_stage_ctl            r_in_ctl;
    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic                  w_en;
    logic                  w_ser_ready;

    t_stage_ctl            w_ctl [0:N_STAGES];
    logic [BCD_W-1:0]      w_bcd [0:N_STAGES];
    logic [VALUE_BITS-1:0] w_bin [0:N_STAGES];

    // The pipeline moves unless a finished number waits on the serialiser.
    assign w_en = !w_ctl[N_STAGES].valid || w_ser_ready;
    assign busy = !w_en;

    // Magnitude in unsigned arithmetic, so the most negative value is exact.
    assign n_mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_en) begin
            r_in_ctl.valid <= start;
            r_in_ctl.neg   <= i_value[VALUE_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag <= n_mag;
        end
    end

    assign w_ctl[0] = r_in_ctl;
    assign w_bcd[0] = '0;
    assign w_bin[0] = r_mag;

    // Chain of double dabble stages; the last one may take fewer steps.
    for (genvar g = 0; g < N_STAGES; g++) begin : g_dabble
        localparam int REST  = VALUE_BITS - g * STEPS_PER_STAGE;
        localparam int STEPS = (REST < STEPS_PER_STAGE) ? REST : STEPS_PER_STAGE;

        sbda_dabble_stage #(
            .VALUE_BITS (VALUE_BITS),
            .N_STEPS    (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_bcd   (w_bcd[g]),
            .i_bin   (w_bin[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_bcd   (w_bcd[g+1]),
            .o_bin   (w_bin[g+1])
        );
    end

    // Character output.
    sbda_serializer #(
        .VALUE_BITS (VALUE_BITS)
    ) u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl[N_STAGES]),
        .i_bcd       (w_bcd[N_STAGES]),
        .o_ready     (w_ser_ready),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

`ifndef ASSERT_OFF
    // A character that is not the last is always followed by another.
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_char |=> o_strobe)
        else $error("character run broken before its last character");

    // A minus sign is followed by a digit.
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_character == ASCII_MINUS) |=>
        o_strobe && (o_character != ASCII_MINUS))
        else $error("minus sign not followed by a digit");

    // Busy only while a finished number waits at the end of the pipeline.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_ctl[N_STAGES].valid && !w_ser_ready)
        else $error("busy raised without a waiting number");
`endif

endmodule

>>> rtl/sbda_dabble_stage.sv
// One register stage of the double dabble binary to BCD converter.
// Performs a fixed number of add-3 and shift steps, then registers the result.
// Depends on sbda_pkg.
module sbda_dabble_stage
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int N_STEPS    = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  t_stage_ctl                                  i_ctl,
    input  logic [num_digits(VALUE_BITS)*DIGIT_BITS-1:0] i_bcd,
    input  logic [VALUE_BITS-1:0]                       i_bin,
    output t_stage_ctl                                  o_ctl,
    output logic [num_digits(VALUE_BITS)*DIGIT_BITS-1:0] o_bcd,
    output logic [VALUE_BITS-1:0]                       o_bin
);

    localparam int N_DIGITS = num_digits(VALUE_BITS);
    localparam int BCD_W    = N_DIGITS * DIGIT_BITS;

    logic [BCD_W-1:0]      n_bcd;
    logic [VALUE_BITS-1:0] n_bin;
    t_stage_ctl            r_ctl;
    logic [BCD_W-1:0]      r_bcd;
    logic [VALUE_BITS-1:0] r_bin;

    // Each step corrects every digit of five or more, then shifts in one bit.
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < N_STEPS; s++) begin
            for (int d = 0; d < N_DIGITS; d++) begin
                if (n_bcd[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                    n_bcd[d*DIGIT_BITS +: DIGIT_BITS] =
                        n_bcd[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_BITS-1]};
            n_bin = {n_bin[VALUE_BITS-2:0], 1'b0};
        end
    end

    // Control is reset; the data registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_ctl = r_ctl;
    assign o_bcd = r_bcd;
    assign o_bin = r_bin;

endmodule

>>> rtl/sbda_serializer.sv
// Output serialiser: strips leading zeros and sends the sign and the digits
// one character per cycle, marking the last one. Depends on sbda_pkg.
module sbda_serializer
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_stage_ctl                                  i_ctl,
    input  logic [num_digits(VALUE_BITS)*DIGIT_BITS-1:0] i_bcd,
    output logic                                        o_ready,
    output logic                                        o_strobe,
    output logic [7:0]                                  o_character,
    output logic                                        o_last_char
);

    localparam int N_DIGITS = num_digits(VALUE_BITS);
    localparam int BCD_W    = N_DIGITS * DIGIT_BITS;
    localparam int CNT_W    = $clog2(N_DIGITS + 1);

    t_ser_state       r_state;
    t_ser_state       n_state;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] w_ndig;
    logic [BCD_W-1:0] w_aligned;

    // Count significant digits; zero still has one.
    always_comb begin
        w_ndig = CNT_W'(1);
        for (int k = 0; k < N_DIGITS; k++) begin
            if (i_bcd[k*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                w_ndig = CNT_W'(k + 1);
            end
        end
    end

    // Move the most significant digit to the top of the word.
    always_comb begin
        w_aligned = i_bcd;
        for (int k = 0; k < N_DIGITS; k++) begin
            if (w_ndig == CNT_W'(k + 1)) begin
                w_aligned = i_bcd << (DIGIT_BITS * (N_DIGITS - 1 - k));
            end
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SER_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_left <= n_left;
    end

    // Next state and outputs; a new number loads as the last character leaves.
    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_left      = r_left;
        o_ready     = 1'b0;
        o_strobe    = 1'b0;
        o_last_char = 1'b0;
        o_character = ASCII_ZERO + {4'b0000, r_bcd[BCD_W-1 -: DIGIT_BITS]};
        case (r_state)
            SER_IDLE: begin
                o_ready = 1'b1;
            end
            SER_SIGN: begin
                o_strobe    = 1'b1;
                o_character = ASCII_MINUS;
                n_state     = SER_DIGITS;
            end
            SER_DIGITS: begin
                o_strobe    = 1'b1;
                o_last_char = (r_left == CNT_W'(1));
                n_bcd       = r_bcd << DIGIT_BITS;
                n_left      = r_left - CNT_W'(1);
                if (o_last_char) begin
                    o_ready = 1'b1;
                    n_state = SER_IDLE;
                end
            end
            default: begin
                n_state = SER_IDLE;
            end
        endcase
        if (o_ready && i_ctl.valid) begin
            n_bcd   = w_aligned;
            n_left  = w_ndig;
            n_state = i_ctl.neg ? SER_SIGN : SER_DIGITS;
        end
    end

endmodule
